// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the framer RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cons must hold whenever ante holds
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication check failed");

// cond must never hold
`define ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");

`else

`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

// ===== hdl/tsf_pkg.sv =====
// Package for the TPM SPI slave framer: codes, command and status types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tsf_pkg;

	localparam int HDR_LEN   = 4;
	localparam int READ_BIT  = 7;
	localparam logic [5:0] LEN_MASK = 6'h3f;
	localparam int BUF_DEPTH = 64;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int CNT_W     = 7;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_READ   = 2'd1,
		KIND_WRITE  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_WDATA  = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_READ = 2'd1,
		BK_EMIT = 2'd2
	} bk_state_t;

	// one queued unit of work for the back end
	typedef struct packed {
		kind_t       kind;
		logic        rdy;
		logic [23:0] addr;
		logic [6:0]  len;
	} cmd_t;

	// data-buffer write port, front to back
	typedef struct packed {
		logic              en;
		logic [BUF_AW-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// back-end status seen by the front end
	typedef struct packed {
		logic bursting;
		logic done;
	} bk_stat_t;

endpackage

// ===== hdl/tsf_cmd_fifo.sv =====
// Two-entry command queue between the framer front and back ends.
// Depends on tsf_pkg (cmd_t).
`timescale 1ns / 1ps

module tsf_cmd_fifo
	import tsf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== hdl/tsf_front.sv =====
// Framer front end: accepts SPI words, parses the header, tracks phase,
// writes data bytes to the back-end buffer and queues commands. Uses tsf_pkg.
`timescale 1ns / 1ps

module tsf_front
	import tsf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     op,
	input  logic [7:0] rx_byte,
	input  logic     q_full,
	output logic     q_push,
	output cmd_t     q_cmd,
	output wr_t      wr,
	input  bk_stat_t bk_stat
);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             stall_q, stall_d;
	logic             busy_q;
	logic [7:0]       hdr0_q, hdr1_q, hdr2_q;
	logic [23:0]      addr_q, addr_d;
	logic [6:0]       len_q, len_d;
	logic             accept;
	logic             burst_push;
	logic [CNT_W-1:0] data_idx;
	logic [CNT_W-1:0] data_cnt;

	// data bytes wait while an earlier burst still reads the buffer
	assign in_ready = !q_full && !(phase_q == PH_WDATA && busy_q);
	assign accept   = in_valid && in_ready;
	assign data_idx = cnt_q - CNT_W'(HDR_LEN);
	assign data_cnt = data_idx + CNT_W'(1);

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		stall_d    = stall_q;
		addr_d     = addr_q;
		len_d      = len_q;
		burst_push = 1'b0;
		q_push     = accept;
		q_cmd      = '{kind: KIND_STATUS, rdy: stall_q, addr: 24'd0, len: 7'd0};
		wr         = '{en: 1'b0, addr: data_idx[BUF_AW-1:0], data: rx_byte};
		if (op) begin
			phase_d = PH_HEADER;
			cnt_d   = '0;
			stall_d = 1'b0;
			q_cmd.rdy = 1'b0;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					cnt_d = cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(HDR_LEN - 1)) begin
						addr_d  = {hdr1_q, hdr2_q, rx_byte};
						len_d   = {1'b0, hdr0_q[5:0] & LEN_MASK} + 7'd1;
						stall_d = 1'b1;
						if (hdr0_q[READ_BIT]) begin
							phase_d = PH_DONE;
							q_cmd   = '{kind: KIND_READ, rdy: 1'b1, addr: addr_d, len: len_d};
						end else begin
							phase_d   = PH_WDATA;
							q_cmd.rdy = 1'b1;
						end
					end
				end
				PH_WDATA: begin
					wr.en = accept;
					cnt_d = cnt_q + CNT_W'(1);
					if (data_cnt >= len_q) begin
						phase_d    = PH_DONE;
						burst_push = accept;
						q_cmd      = '{kind: KIND_WRITE, rdy: stall_q, addr: addr_q, len: len_q};
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= '0;
			stall_q <= 1'b0;
			busy_q  <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				stall_q <= stall_d;
			end
			if (burst_push) busy_q <= 1'b1;
			else if (bk_stat.done) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= addr_d;
			len_q  <= len_d;
			if (!op && phase_q == PH_HEADER) begin
				case (cnt_q[1:0])
					2'd0:    hdr0_q <= rx_byte;
					2'd1:    hdr1_q <= rx_byte;
					2'd2:    hdr2_q <= rx_byte;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== hdl/tsf_back.sv =====
// Framer back end: pops commands, owns the write-data buffer and drives the
// result output register, expanding a write command into a byte burst. Uses tsf_pkg.
`timescale 1ns / 1ps

module tsf_back
	import tsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        q_head,
	input  logic        q_empty,
	output logic        q_pop,
	input  wr_t         wr,
	output bk_stat_t    bk_stat,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [23:0] reg_address,
	output logic [6:0]  transfer_length,
	output logic [7:0]  write_byte,
	output logic [5:0]  byte_offset,
	output logic        last,
	output logic        ready_bit
);

	logic [7:0]        mem [BUF_DEPTH];
	logic [7:0]        rd_q;
	bk_state_t         state_q, state_d;
	logic [BUF_AW-1:0] k_q, k_d;
	cmd_t              cmd_q;
	logic              ov_q;
	logic              slot_free;
	logic              load_cmd;
	logic              load_byte;
	logic              take_burst;
	logic              is_last;
	kind_t             kind_q;
	logic [23:0]       addr_q;
	logic [6:0]        len_q;
	logic [7:0]        wb_q;
	logic [5:0]        off_q;
	logic              last_q;
	logic              rdy_q;

	assign slot_free = !ov_q || out_ready;
	assign is_last   = ({1'b0, k_q} + 7'd1) == cmd_q.len;

	always_comb begin
		state_d    = state_q;
		k_d        = k_q;
		q_pop      = 1'b0;
		load_cmd   = 1'b0;
		load_byte  = 1'b0;
		take_burst = 1'b0;
		bk_stat    = '{bursting: state_q != BK_IDLE, done: 1'b0};
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && slot_free) begin
					q_pop = 1'b1;
					if (q_head.kind == KIND_WRITE) begin
						take_burst = 1'b1;
						k_d        = '0;
						state_d    = BK_READ;
					end else begin
						load_cmd = 1'b1;
					end
				end
			end
			BK_READ: state_d = BK_EMIT;
			BK_EMIT: begin
				if (slot_free) begin
					load_byte = 1'b1;
					if (is_last) begin
						bk_stat.done = 1'b1;
						state_d      = BK_IDLE;
					end else begin
						k_d     = k_q + BUF_AW'(1);
						state_d = BK_READ;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_cmd || load_byte) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		k_q <= k_d;
		if (take_burst) cmd_q <= q_head;
		if (load_cmd) begin
			kind_q <= q_head.kind;
			addr_q <= q_head.addr;
			len_q  <= q_head.len;
			wb_q   <= 8'd0;
			off_q  <= 6'd0;
			last_q <= 1'b1;
			rdy_q  <= q_head.rdy;
		end else if (load_byte) begin
			kind_q <= KIND_WRITE;
			addr_q <= cmd_q.addr;
			len_q  <= cmd_q.len;
			wb_q   <= rd_q;
			off_q  <= 6'(k_q);
			last_q <= is_last;
			rdy_q  <= cmd_q.rdy;
		end
	end

	// buffer: one write port from the front end, one registered read port
	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= wr.data;
		rd_q <= mem[k_q];
	end

	assign out_valid       = ov_q;
	assign kind            = kind_q;
	assign reg_address     = addr_q;
	assign transfer_length = len_q;
	assign write_byte      = wb_q;
	assign byte_offset     = off_q;
	assign last            = last_q;
	assign ready_bit       = rdy_q;

endmodule

// ===== hdl/tpm_spi_slave_framer.sv =====
// Top level of the TPM SPI slave framer.
// Depends on tsf_pkg, tsf_front, tsf_cmd_fifo, tsf_back and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready): one word per SPI event; op 0 carries a
//   received byte in rx_byte, op 1 reports chip-select release.
//   Output channel (out_valid/out_ready): result words. Every input word yields
//   one result, except the final data byte of a write, which yields one
//   write-byte result per buffered byte (1 to 64), the last one flagged.
//   A header's fourth byte yields a read request (read) or a status word
//   with ready_bit 1 (write); release yields a status word with ready_bit 0.
// Result path: with the queue empty and the output register free, a single result
//   passes through the command queue entry and then the output register. A write
//   burst passes through the queue; the back end then runs BK_READ (registered buffer
//   read) and BK_EMIT (output register load, once it is free) for each byte in turn.
// Throughput: one input word per cycle while the two-entry command queue has
//   room. Data bytes of a new write wait while an earlier burst still reads
//   the buffer.
// Reset: arst_n clears framing to header collection with stall cleared and
//   empties queue and output register. No clearing pass is needed.
// Stall: when out_ready is low the output register holds; the queue fills
//   and then in_ready drops, so no word is lost.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpm_spi_slave_framer
	import tsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [23:0] reg_address,
	output logic [6:0]  transfer_length,
	output logic [7:0]  write_byte,
	output logic [5:0]  byte_offset,
	output logic        last,
	output logic        ready_bit
);

	// queue signals between front and back
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;
	cmd_t     q_cmd;
	cmd_t     q_head;
	// buffer write and back-end status
	wr_t      wr;
	bk_stat_t bk_stat;

	// front: parse and classify, write data bytes into the buffer
	tsf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd),
		.wr       (wr),
		.bk_stat  (bk_stat)
	);

	tsf_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// back: turn commands into result words
	tsf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_head          (q_head),
		.q_empty         (q_empty),
		.q_pop           (q_pop),
		.wr              (wr),
		.bk_stat         (bk_stat),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.reg_address     (reg_address),
		.transfer_length (transfer_length),
		.write_byte      (write_byte),
		.byte_offset     (byte_offset),
		.last            (last),
		.ready_bit       (ready_bit)
	);

	// the front never pushes into a full queue
	`ASSERT_NEVER(a_no_overflow, clk, arst_n, q_push && q_full)
	// the buffer is never overwritten while a burst reads it
	`ASSERT_IMPLIES(a_no_wr_in_burst, clk, arst_n, wr.en, !bk_stat.bursting)
	// a write-byte result lies inside its transfer
	`ASSERT_IMPLIES(a_offset_in_range, clk, arst_n, out_valid && kind == KIND_WRITE, 7'(byte_offset) < transfer_length)

endmodule
